// File: src/psm_pkg.sv
// Shared constants, pipeline record type and divider step for the pair similarity metrics core.
`default_nettype none
package psm_pkg;

    localparam int LEN_BITS  = 40;
    localparam int FRAC_BITS = 16;

    localparam int Q_W       = FRAC_BITS + 1;
    localparam int SUM_W     = LEN_BITS + 1;
    localparam int PROD_W    = 2 * LEN_BITS;
    localparam int HALF      = LEN_BITS / 2;
    localparam int HI_W      = LEN_BITS - HALF;
    localparam int REM_W     = LEN_BITS + 2;
    localparam int SQ_REM_W  = LEN_BITS + 2;
    localparam int EUC_BITS  = (LEN_BITS + 2) / 2;
    localparam int MAN_PAD_W = 2 * EUC_BITS;
    localparam int EUC_REM_W = EUC_BITS + 2;
    localparam int ID_W      = FRAC_BITS + 2;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    // stage plan
    localparam int ST_PROD      = 1;
    localparam int ST_SQ0       = 2;
    localparam int ST_ID_SETUP  = ST_SQ0 + FRAC_BITS;
    localparam int ST_COS_SETUP = ST_SQ0 + LEN_BITS;
    localparam int ID_END       = ST_ID_SETUP + FRAC_BITS;
    localparam int COS_END      = ST_COS_SETUP + FRAC_BITS;
    localparam int DEPTH        = ((COS_END > ID_END) ? COS_END : ID_END) + 1;

    localparam int IN_W  = 3 * LEN_BITS;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 4 * Q_W + EUC_BITS + SUM_W + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [LEN_BITS-1:0]   inter;
        logic [SUM_W-1:0]      man;
        logic [2*HALF-1:0]     p_ll;
        logic [LEN_BITS-1:0]   p_hl;
        logic [LEN_BITS-1:0]   p_lh;
        logic [2*HI_W-1:0]     p_hh;
        logic [PROD_W-1:0]     cx;
        logic [SQ_REM_W-1:0]   crem;
        logic [LEN_BITS-1:0]   croot;
        logic [MAN_PAD_W-1:0]  mx;
        logic [EUC_REM_W-1:0]  mrem;
        logic [EUC_BITS-1:0]   mroot;
        logic [REM_W-1:0]      jrem;
        logic [REM_W-1:0]      jden;
        logic [Q_W-1:0]        jq;
        logic                  jsat;
        logic [REM_W-1:0]      drem;
        logic [REM_W-1:0]      dden;
        logic [Q_W-1:0]        dq;
        logic                  dsat;
        logic [ID_W-1:0]       irem;
        logic [ID_W-1:0]       iden;
        logic [Q_W-1:0]        iq;
        logic                  isat;
        logic [REM_W-1:0]      qrem;
        logic [REM_W-1:0]      qden;
        logic [Q_W-1:0]        cq;
        logic                  csat;
        logic                  zu;
        logic                  zp;
        logic                  zs;
    } pipe_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q;
    } div_res_t;

    // one restoring division step
    function automatic div_res_t div_step(input logic [REM_W-1:0] rem,
                                          input logic [REM_W-1:0] den);
        logic [REM_W:0] r2;
        div_res_t       res;
        r2    = {rem, 1'b0};
        res.q = 1'b0;
        if (r2 >= {1'b0, den})
        begin
            r2    = r2 - {1'b0, den};
            res.q = 1'b1;
        end
        res.rem = r2[REM_W-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/psm_pipe.sv
// Pipelined datapath: products, digit-by-digit square roots and fraction dividers.
`default_nettype none
module psm_pipe
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          in_valid,
    input  wire logic [psm_pkg::LEN_BITS-1:0]  in_a,
    input  wire logic [psm_pkg::LEN_BITS-1:0]  in_b,
    input  wire logic [psm_pkg::LEN_BITS-1:0]  in_i,
    output logic                               out_valid,
    output psm_pkg::pipe_t                     out_data
);

    localparam int L  = psm_pkg::LEN_BITS;
    localparam int D  = psm_pkg::DEPTH;
    localparam int RW = psm_pkg::REM_W;

    logic [D-1:0]   valid_reg;
    psm_pkg::pipe_t stage_reg  [D];
    psm_pkg::pipe_t stage_next [D];

    function automatic psm_pkg::pipe_t entry(input logic [L-1:0] a,
                                             input logic [L-1:0] b,
                                             input logic [L-1:0] i);
        psm_pkg::pipe_t                  s;
        logic [psm_pkg::SUM_W-1:0]       sum;
        logic [psm_pkg::SUM_W-1:0]       twice;
        logic [psm_pkg::SUM_W-1:0]       uni;
        s       = '0;
        sum     = psm_pkg::SUM_W'(a) + psm_pkg::SUM_W'(b);
        twice   = {i, 1'b0};
        uni     = (sum > psm_pkg::SUM_W'(i)) ? sum - psm_pkg::SUM_W'(i) : '0;
        s.man   = (sum > twice) ? sum - twice : '0;
        s.inter = i;
        s.p_ll  = a[psm_pkg::HALF-1:0] * b[psm_pkg::HALF-1:0];
        s.p_hl  = a[L-1:psm_pkg::HALF] * b[psm_pkg::HALF-1:0];
        s.p_lh  = a[psm_pkg::HALF-1:0] * b[L-1:psm_pkg::HALF];
        s.p_hh  = a[L-1:psm_pkg::HALF] * b[L-1:psm_pkg::HALF];
        s.mx    = psm_pkg::MAN_PAD_W'(s.man);
        s.jrem  = RW'(i);
        s.jden  = RW'(uni);
        s.jsat  = psm_pkg::SUM_W'(i) >= uni;
        s.zu    = (uni == '0);
        s.drem  = RW'(twice);
        s.dden  = RW'(sum);
        s.dsat  = twice >= sum;
        s.zs    = (sum == '0);
        return s;
    endfunction

    function automatic psm_pkg::pipe_t step(input int k, input psm_pkg::pipe_t p);
        psm_pkg::pipe_t                 s;
        psm_pkg::div_res_t              dr;
        logic [psm_pkg::SQ_REM_W+1:0]   cw;
        logic [psm_pkg::SQ_REM_W+1:0]   ct;
        logic [psm_pkg::EUC_REM_W+1:0]  mw;
        logic [psm_pkg::EUC_REM_W+1:0]  mt;
        logic [psm_pkg::Q_W-1:0]        j;
        s = p;
        if (k == psm_pkg::ST_PROD)
        begin
            s.cx    = (psm_pkg::PROD_W'(p.p_hh) << (2 * psm_pkg::HALF))
                    + ((psm_pkg::PROD_W'(p.p_hl) + psm_pkg::PROD_W'(p.p_lh)) << psm_pkg::HALF)
                    + psm_pkg::PROD_W'(p.p_ll);
            s.crem  = '0;
            s.croot = '0;
        end
        if (k >= psm_pkg::ST_SQ0 && k < psm_pkg::ST_SQ0 + L)
        begin
            cw = {p.crem, p.cx[psm_pkg::PROD_W-1 -: 2]};
            ct = {2'b00, p.croot, 2'b01};
            s.cx = p.cx << 2;
            if (cw >= ct)
            begin
                s.crem  = psm_pkg::SQ_REM_W'(cw - ct);
                s.croot = {p.croot[L-2:0], 1'b1};
            end
            else
            begin
                s.crem  = psm_pkg::SQ_REM_W'(cw);
                s.croot = {p.croot[L-2:0], 1'b0};
            end
        end
        if (k >= psm_pkg::ST_SQ0 && k < psm_pkg::ST_SQ0 + psm_pkg::EUC_BITS)
        begin
            mw = {p.mrem, p.mx[psm_pkg::MAN_PAD_W-1 -: 2]};
            mt = {2'b00, p.mroot, 2'b01};
            s.mx = p.mx << 2;
            if (mw >= mt)
            begin
                s.mrem  = psm_pkg::EUC_REM_W'(mw - mt);
                s.mroot = {p.mroot[psm_pkg::EUC_BITS-2:0], 1'b1};
            end
            else
            begin
                s.mrem  = psm_pkg::EUC_REM_W'(mw);
                s.mroot = {p.mroot[psm_pkg::EUC_BITS-2:0], 1'b0};
            end
        end
        if (k >= psm_pkg::ST_SQ0 && k < psm_pkg::ST_ID_SETUP)
        begin
            dr     = psm_pkg::div_step(p.jrem, p.jden);
            s.jrem = dr.rem;
            s.jq   = {p.jq[psm_pkg::Q_W-2:0], dr.q};
            dr     = psm_pkg::div_step(p.drem, p.dden);
            s.drem = dr.rem;
            s.dq   = {p.dq[psm_pkg::Q_W-2:0], dr.q};
        end
        if (k == psm_pkg::ST_ID_SETUP)
        begin
            j      = p.jsat ? psm_pkg::ONE_Q : p.jq;
            s.isat = j[psm_pkg::FRAC_BITS];
            s.irem = {1'b0, j};
            s.irem = s.irem << 1;
            s.iden = psm_pkg::ID_W'(psm_pkg::ONE_Q) + psm_pkg::ID_W'(j);
            s.iq   = '0;
        end
        if (k > psm_pkg::ST_ID_SETUP && k <= psm_pkg::ID_END)
        begin
            dr     = psm_pkg::div_step(RW'(p.irem), RW'(p.iden));
            s.irem = psm_pkg::ID_W'(dr.rem);
            s.iq   = {p.iq[psm_pkg::Q_W-2:0], dr.q};
        end
        if (k == psm_pkg::ST_COS_SETUP)
        begin
            s.qrem = RW'(p.inter);
            s.qden = RW'(p.croot);
            s.csat = p.inter >= p.croot;
            s.zp   = (p.croot == '0);
            s.cq   = '0;
        end
        if (k > psm_pkg::ST_COS_SETUP && k <= psm_pkg::COS_END)
        begin
            dr     = psm_pkg::div_step(p.qrem, p.qden);
            s.qrem = dr.rem;
            s.cq   = {p.cq[psm_pkg::Q_W-2:0], dr.q};
        end
        return s;
    endfunction

    always_comb
    begin
        stage_next[0] = entry(in_a, in_b, in_i);
        for (int k = 1; k < D; k++)
        begin
            stage_next[k] = step(k, stage_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[D-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < D; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[D-1];
    assign out_data  = stage_reg[D-1];

endmodule
`default_nettype wire

// File: src/pair_similarity_metrics_core.sv
// Top level of the pair similarity metrics core: stream ports, mode register, result packing.
// Takes one set pair per cycle unless held and returns one result per pair; pipeline depth
// psm_pkg::DEPTH is set by the 40 one-bit steps of the square root of A*B followed by the
// 16 quotient steps of the cosine divider. The whole pipeline holds while a finished result
// is not taken. Mode is to be changed by the user only while idle; the core does not enforce it.
`default_nettype none
module pair_similarity_metrics_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // length_a, length_b, shared_length
    input  wire logic [psm_pkg::IN_TW-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // jaccard_q, cosine_q, dice_q, identity_q, euclid_dist, manhattan_dist,
    // zero_denominator, zero pad
    output logic [psm_pkg::OUT_TW-1:0]         m_axis_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_data
);

    localparam int L = psm_pkg::LEN_BITS;
    localparam int Q = psm_pkg::Q_W;

    logic           mode_reg;
    logic           mode_next;
    logic           advance;
    logic           pipe_valid;
    psm_pkg::pipe_t res;
    logic [Q-1:0]   jac;
    logic [Q-1:0]   cosv;
    logic [Q-1:0]   dice;
    logic [Q-1:0]   ident;

    function automatic logic [psm_pkg::Q_W-1:0] present(input logic zero,
                                                        input logic sat,
                                                        input logic [psm_pkg::Q_W-1:0] q,
                                                        input logic dist_sel);
        logic [psm_pkg::Q_W-1:0] v;
        v = sat ? psm_pkg::ONE_Q : q;
        if (dist_sel)
        begin
            v = psm_pkg::ONE_Q - v;
        end
        return zero ? '0 : v;
    endfunction

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data[0] : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign advance       = !pipe_valid || m_axis_tready;
    assign s_axis_tready = advance;

    psm_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .in_a      (s_axis_tdata[L-1:0]),
        .in_b      (s_axis_tdata[2*L-1:L]),
        .in_i      (s_axis_tdata[3*L-1:2*L]),
        .out_valid (pipe_valid),
        .out_data  (res)
    );

    assign jac   = present(res.zu, res.jsat, res.jq, mode_reg);
    assign cosv  = present(res.zp, res.csat, res.cq, mode_reg);
    assign dice  = present(res.zs, res.dsat, res.dq, mode_reg);
    assign ident = present(res.zu, res.isat, res.iq, mode_reg);

    assign m_axis_tvalid = pipe_valid;
    assign m_axis_tdata  = psm_pkg::OUT_TW'({res.zu | res.zp | res.zs, res.man, res.mroot,
                                             ident, dice, cosv, jac});

endmodule
`default_nettype wire

// File: src/psm_checker.sv
// Port-level checker for the pair similarity metrics core, with its bind.
`default_nettype none
module psm_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [psm_pkg::OUT_TW-1:0]    m_axis_tdata,
    input wire logic                          cfg_ready
);

    localparam int Q  = psm_pkg::Q_W;
    localparam int EB = 4 * Q;
    localparam int MB = EB + psm_pkg::EUC_BITS;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with empty output");

    a_jaccard_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[Q-1:0] <= psm_pkg::ONE_Q)
        else $error("jaccard above one");

    a_euclid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[MB+psm_pkg::SUM_W-1:MB] == '0
        |-> m_axis_tdata[MB-1:EB] == '0)
        else $error("euclid nonzero with zero manhattan");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config channel stalled");

endmodule

bind pair_similarity_metrics_core psm_checker u_psm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);
`default_nettype wire

// File: tb/sv/tb_pair_similarity_metrics_core.sv
// Self-checking testbench for the pair similarity metrics core: random and corner pairs, both modes.
`default_nettype none
module tb_pair_similarity_metrics_core;

    localparam int LW = psm_pkg::LEN_BITS;
    localparam logic [LW-1:0] LMAX = {LW{1'b1}};

    typedef struct packed {
        logic                              zflag;
        logic [psm_pkg::SUM_W-1:0]         man;
        logic [psm_pkg::EUC_BITS-1:0]      euc;
        logic [psm_pkg::Q_W-1:0]           ident;
        logic [psm_pkg::Q_W-1:0]           dice;
        logic [psm_pkg::Q_W-1:0]           cosq;
        logic [psm_pkg::Q_W-1:0]           jac;
    } metrics_t;

    class metrics_scoreboard;
        metrics_t pending[$];
        bit       dist_mode;
        int       errors;

        function new();
            dist_mode = 0;
            errors    = 0;
        endfunction

        // floor(num * 2^FRAC_BITS / den), saturated at one
        function logic [psm_pkg::Q_W-1:0] frac(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            if (num >= den)
                return psm_pkg::ONE_Q;
            q = (num << psm_pkg::FRAC_BITS) / den;
            return q[psm_pkg::Q_W-1:0];
        endfunction

        function logic [127:0] isqrt(logic [127:0] v);
            logic [127:0] r;
            logic [127:0] c;
            r = 0;
            for (int b = 63; b >= 0; b--)
            begin
                c = r | (128'd1 << b);
                if (c * c <= v)
                    r = c;
            end
            return r;
        endfunction

        function logic [psm_pkg::Q_W-1:0] shown(logic [psm_pkg::Q_W-1:0] q);
            return dist_mode ? psm_pkg::ONE_Q - q : q;
        endfunction

        function void note_pair(logic [LW-1:0] a, logic [LW-1:0] b, logic [LW-1:0] i);
            metrics_t                m;
            logic [127:0]            sum;
            logic [127:0]            twice;
            logic [127:0]            uni;
            logic [127:0]            s;
            logic [127:0]            euc_full;
            logic [psm_pkg::Q_W-1:0] j;
            m        = '0;
            sum      = 128'(a) + 128'(b);
            twice    = 128'({i, 1'b0});
            uni      = (sum > 128'(i)) ? sum - 128'(i) : 128'd0;
            m.man    = psm_pkg::SUM_W'((sum > twice) ? sum - twice : 128'd0);
            euc_full = isqrt(128'(m.man));
            m.euc    = euc_full[psm_pkg::EUC_BITS-1:0];
            if (uni != 0)
            begin
                j       = frac(128'(i), uni);
                m.jac   = shown(j);
                m.ident = shown(frac(128'({j, 1'b0}), 128'(psm_pkg::ONE_Q) + 128'(j)));
            end
            else
                m.zflag = 1;
            s = isqrt(128'(a) * 128'(b));
            if (s != 0)
                m.cosq = shown(frac(128'(i), s));
            else
                m.zflag = 1;
            if (sum != 0)
                m.dice = shown(frac(twice, sum));
            else
                m.zflag = 1;
            pending.insert(pending.size(), m);
        endfunction

        function void check_result(metrics_t got);
            metrics_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.jac !== e.jac)
            begin $error("jaccard_q exp %0d got %0d", e.jac, got.jac); errors++; end
            if (got.cosq !== e.cosq)
            begin $error("cosine_q exp %0d got %0d", e.cosq, got.cosq); errors++; end
            if (got.dice !== e.dice)
            begin $error("dice_q exp %0d got %0d", e.dice, got.dice); errors++; end
            if (got.ident !== e.ident)
            begin $error("identity_q exp %0d got %0d", e.ident, got.ident); errors++; end
            if (got.euc !== e.euc)
            begin $error("euclid_dist exp %0d got %0d", e.euc, got.euc); errors++; end
            if (got.man !== e.man)
            begin $error("manhattan_dist exp %0d got %0d", e.man, got.man); errors++; end
            if (got.zflag !== e.zflag)
            begin
                $error("zero_denominator exp %0d got %0d", e.zflag, got.zflag);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [psm_pkg::IN_TW-1:0]      s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [psm_pkg::OUT_TW-1:0]     m_axis_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [0:0]                     cfg_data;

    metrics_scoreboard sb;
    int  hold_off;
    bit  stim_done;

    pair_similarity_metrics_core DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic logic [LW-1:0] rand_len();
        logic [LW-1:0] v;
        v = LW'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: return v >> $urandom_range(0, LW - 1);
            1: return v & LW'('hFF);
            2: return LMAX - LW'($urandom_range(0, 3));
            default: return v;
        endcase
    endfunction

    task automatic send_pair(logic [LW-1:0] a, logic [LW-1:0] b, logic [LW-1:0] i);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= psm_pkg::IN_TW'({i, b, a});
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_pair(a, b, i);
        @(negedge clk);
    endtask

    task automatic send_related();
        logic [LW-1:0] a;
        logic [LW-1:0] b;
        logic [LW-1:0] i;
        logic [LW-1:0] m;
        a = rand_len();
        b = rand_len();
        m = (a < b) ? a : b;
        case ($urandom_range(0, 7))
            0: i = rand_len();
            1: i = m;
            default: i = (m == 0) ? 0 : LW'({$urandom, $urandom} % (64'(m) + 1));
        endcase
        send_pair(a, b, i);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (psm_pkg::DEPTH + 5) @(negedge clk);
    endtask

    task automatic write_mode(bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.dist_mode = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_set();
        send_pair(0, 0, 0);
        send_pair(LMAX, LMAX, LMAX);
        send_pair(LMAX, LMAX, 0);
        send_pair(0, LMAX, 0);
        send_pair(LMAX, 0, 5);
        send_pair(5, 3, 10);
        send_pair(1, 1, 1);
        send_pair(1, 1, 0);
        send_pair(3, 7, 2);
        send_pair(10, 10, 7);
        send_pair(LMAX, 1, 1);
        send_pair(1, LMAX, LMAX);
        send_pair(4, 4, 9);
        send_pair(LW'(40'hAAAAAAAAAA), LW'(40'h5555555555), LW'(40'h5555555555));
        send_pair(LW'(40'h5555555555), LW'(40'hAAAAAAAAAA), LW'(40'hAAAAAAAAAA));
        send_pair(100, 200, 0);
    endtask

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(metrics_t'(m_axis_tdata[psm_pkg::OUT_W-1:0]));

    initial
    begin
        int wait_cyc;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end
            else
            begin
                wait_cyc = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
                if (stim_done || wait_cyc == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cyc) @(negedge clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        sb            = new();
        hold_off      = 0;
        stim_done     = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        directed_set();
        drain();
        write_mode(1'b1);
        directed_set();
        drain();
        write_mode(1'b0);

        // long receiver stall while pairs keep coming
        hold_off = 1000;
        repeat (120) send_related();
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_mode(ph[0]);
            repeat (165) send_related();
            drain();
        end

        stim_done = 1;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
